@@ sv/bcm_pkg.sv @@
// bcm_pkg: shared types and constants of the bounding circle merge unit
package bcm_pkg;

    localparam int COORD_W   = 32;
    localparam int RADIUS_W  = 31;
    localparam int ABS_W     = 32;
    localparam int SQ_W      = 65;
    localparam int RADICAND_W = 66;
    localparam int ROOT_W    = 33;
    localparam int QUO_W     = 33;
    localparam int DVD_W     = 65;
    localparam int MID_DEPTH = 8;
    localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
    localparam int OUT_DEPTH = 2;

    typedef struct packed {
        logic signed [COORD_W-1:0]  a_x;
        logic signed [COORD_W-1:0]  a_y;
        logic        [RADIUS_W-1:0] a_radius;
        logic signed [COORD_W-1:0]  b_x;
        logic signed [COORD_W-1:0]  b_y;
        logic        [RADIUS_W-1:0] b_radius;
    } t_item;

    typedef struct packed {
        logic signed [COORD_W-1:0]  merged_x;
        logic signed [COORD_W-1:0]  merged_y;
        logic        [RADIUS_W-1:0] merged_radius;
        logic        [RADIUS_W-1:0] growth;
        logic                       overlapping;
    } t_result;

    typedef struct packed {
        logic signed [COORD_W-1:0]  ax;
        logic signed [COORD_W-1:0]  ay;
        logic signed [COORD_W-1:0]  bx;
        logic signed [COORD_W-1:0]  by;
        logic        [RADIUS_W-1:0] ra;
        logic        [RADIUS_W-1:0] rb;
        logic        [ABS_W-1:0]    ux;
        logic        [ABS_W-1:0]    uy;
        logic                       neg_x;
        logic                       neg_y;
        logic                       pick_a;
        logic                       encl;
        logic                       ovl;
    } t_geo;

    typedef struct packed {
        t_geo             geo;
        logic [SQ_W-1:0]  sq;
    } t_cls;

    typedef struct packed {
        t_geo              geo;
        logic [ROOT_W-1:0] rad;
    } t_dpl;

endpackage

@@ sv/bcm_fifo.sv @@
// bcm_fifo: small register queue with count and status
module bcm_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [W-1:0]               i_data,
    input  logic                       i_pop,
    output logic [W-1:0]               o_data,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

@@ sv/bcm_front.sv @@
// bcm_front: input stage, squared distance and enclosure/overlap classification
module bcm_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  bcm_pkg::t_item               i_item,
    output logic                         o_full,
    input  logic [bcm_pkg::MID_CNT_W-1:0] i_mid_count,
    output logic                         o_mid_push,
    output bcm_pkg::t_cls                o_mid_data
);
    logic                 r_v1, r_v2;
    bcm_pkg::t_geo        r_g1, r_g2, n_g1;
    logic [30:0]          r_diff;
    logic [31:0]          r_sum;
    logic [63:0]          r_sx, r_sy, r_ss;
    logic [61:0]          r_dd;
    logic signed [32:0]   dx, dy;
    logic [bcm_pkg::MID_CNT_W:0] inflight;
    logic                 take;
    logic [bcm_pkg::SQ_W-1:0] sq;

    assign inflight = {1'b0, i_mid_count} + (bcm_pkg::MID_CNT_W+1)'(r_v1)
                    + (bcm_pkg::MID_CNT_W+1)'(r_v2);
    assign o_full   = (inflight >= (bcm_pkg::MID_CNT_W+1)'(bcm_pkg::MID_DEPTH));
    assign take     = i_push && !o_full;

    always_comb begin
        dx = {i_item.b_x[31], i_item.b_x} - {i_item.a_x[31], i_item.a_x};
        dy = {i_item.b_y[31], i_item.b_y} - {i_item.a_y[31], i_item.a_y};
        n_g1.ax     = i_item.a_x;
        n_g1.ay     = i_item.a_y;
        n_g1.bx     = i_item.b_x;
        n_g1.by     = i_item.b_y;
        n_g1.ra     = i_item.a_radius;
        n_g1.rb     = i_item.b_radius;
        n_g1.neg_x  = dx[32];
        n_g1.neg_y  = dy[32];
        n_g1.ux     = dx[32] ? 32'(-dx) : dx[31:0];
        n_g1.uy     = dy[32] ? 32'(-dy) : dy[31:0];
        n_g1.pick_a = (i_item.a_radius > i_item.b_radius);
        n_g1.encl   = 1'b0;
        n_g1.ovl    = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= take;
            r_v2 <= r_v1;
        end
        r_g1   <= n_g1;
        r_diff <= n_g1.pick_a ? i_item.a_radius - i_item.b_radius
                              : i_item.b_radius - i_item.a_radius;
        r_sum  <= {1'b0, i_item.a_radius} + {1'b0, i_item.b_radius};
        r_g2   <= r_g1;
        r_sx   <= r_g1.ux * r_g1.ux;
        r_sy   <= r_g1.uy * r_g1.uy;
        r_dd   <= r_diff * r_diff;
        r_ss   <= r_sum * r_sum;
    end

    always_comb begin
        sq = {1'b0, r_sx} + {1'b0, r_sy};
        o_mid_data.geo      = r_g2;
        o_mid_data.geo.encl = (sq <= {3'b000, r_dd});
        o_mid_data.geo.ovl  = (sq <= {1'b0, r_ss});
        o_mid_data.sq       = sq;
    end
    assign o_mid_push = r_v2;
endmodule

@@ sv/bcm_isqrt.sv @@
// bcm_isqrt: pipelined integer square root, one result bit per stage
module bcm_isqrt #(
    parameter int PW = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic [bcm_pkg::RADICAND_W-1:0]     i_rad,
    input  logic [PW-1:0]                      i_pl,
    output logic                               o_valid,
    output logic [bcm_pkg::ROOT_W-1:0]         o_root,
    output logic [PW-1:0]                      o_pl
);
    localparam int N  = bcm_pkg::ROOT_W;
    localparam int RW = bcm_pkg::ROOT_W + 2;

    logic [RW-1:0]                     r_rem [N];
    logic [N-1:0]                      r_res [N];
    logic [bcm_pkg::RADICAND_W-1:0]    r_rad [N];
    logic [PW-1:0]                     r_pl  [N];
    logic [N-1:0]                      r_v;

    for (genvar g = 0; g < N; g++) begin : g_step
        localparam int P = 2 * (N - 1 - g);
        logic [RW-1:0]                  rem_in;
        logic [N-1:0]                   res_in;
        logic [bcm_pkg::RADICAND_W-1:0] rad_in;
        logic [PW-1:0]                  pl_in;
        logic                           v_in;
        logic [RW+1:0]                  rem_sh, trial;
        logic                           ge;
        if (g == 0) begin : g_first
            assign rem_in = '0;
            assign res_in = '0;
            assign rad_in = i_rad;
            assign pl_in  = i_pl;
            assign v_in   = i_valid;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign res_in = r_res[g-1];
            assign rad_in = r_rad[g-1];
            assign pl_in  = r_pl[g-1];
            assign v_in   = r_v[g-1];
        end
        assign rem_sh = {rem_in, rad_in[P+1:P]};
        assign trial  = {2'b00, res_in, 2'b01};
        assign ge     = (rem_sh >= trial);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= v_in;
            end
            if (i_en) begin
                r_rem[g] <= ge ? RW'(rem_sh - trial) : RW'(rem_sh);
                r_res[g] <= {res_in[N-2:0], ge};
                r_rad[g] <= rad_in;
                r_pl[g]  <= pl_in;
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_root  = r_res[N-1];
    assign o_pl    = r_pl[N-1];
endmodule

@@ sv/bcm_div.sv @@
// bcm_div: two-lane pipelined restoring divider with shared divisor
module bcm_div #(
    parameter int PW = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [bcm_pkg::DVD_W-1:0]     i_dvd [2],
    input  logic [bcm_pkg::ROOT_W-1:0]    i_dsr,
    input  logic [PW-1:0]                 i_pl,
    output logic                          o_valid,
    output logic [bcm_pkg::QUO_W-1:0]     o_quo [2],
    output logic [PW-1:0]                 o_pl
);
    localparam int N  = bcm_pkg::QUO_W;
    localparam int DW = bcm_pkg::ROOT_W;

    logic [DW-1:0]                 r_dsr [N];
    logic [PW-1:0]                 r_pl  [N];
    logic [N-1:0]                  r_v;

    for (genvar g = 0; g < N; g++) begin : g_ctl
        logic [DW-1:0] dsr_in;
        logic [PW-1:0] pl_in;
        logic          v_in;
        if (g == 0) begin : g_first
            assign dsr_in = i_dsr;
            assign pl_in  = i_pl;
            assign v_in   = i_valid;
        end else begin : g_next
            assign dsr_in = r_dsr[g-1];
            assign pl_in  = r_pl[g-1];
            assign v_in   = r_v[g-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= v_in;
            end
            if (i_en) begin
                r_dsr[g] <= dsr_in;
                r_pl[g]  <= pl_in;
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [DW-1:0]                 r_rem [N];
        logic [N-1:0]                  r_q   [N];
        logic [bcm_pkg::DVD_W-1:0]     r_dvd [N];
        for (genvar g = 0; g < N; g++) begin : g_step
            localparam int B = N - 1 - g;
            logic [DW-1:0]             rem_in, dsr_in;
            logic [N-1:0]              q_in;
            logic [bcm_pkg::DVD_W-1:0] dvd_in;
            logic [DW:0]               rem_sh;
            logic                      ge;
            if (g == 0) begin : g_first
                assign rem_in = {1'b0, i_dvd[l][bcm_pkg::DVD_W-1:N]};
                assign q_in   = '0;
                assign dvd_in = i_dvd[l];
                assign dsr_in = i_dsr;
            end else begin : g_next
                assign rem_in = r_rem[g-1];
                assign q_in   = r_q[g-1];
                assign dvd_in = r_dvd[g-1];
                assign dsr_in = r_dsr[g-1];
            end
            assign rem_sh = {rem_in, dvd_in[B]};
            assign ge     = (rem_sh >= {1'b0, dsr_in});
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= ge ? DW'(rem_sh - {1'b0, dsr_in}) : DW'(rem_sh);
                    r_q[g]   <= {q_in[N-2:0], ge};
                    r_dvd[g] <= dvd_in;
                end
            end
        end
        assign o_quo[l] = r_q[N-1];
    end

    assign o_valid = r_v[N-1];
    assign o_pl    = r_pl[N-1];
endmodule

@@ sv/bcm_back.sv @@
// bcm_back: root, merged radius, centre offsets and saturation
module bcm_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_mid_empty,
    input  bcm_pkg::t_cls    i_mid_data,
    output logic             o_mid_pop,
    input  logic             i_out_full,
    output logic             o_out_push,
    output bcm_pkg::t_result o_out_data
);
    logic                          en;
    logic                          sq_v, r_rv, r_mv, dv_v;
    logic [bcm_pkg::ROOT_W-1:0]    root;
    bcm_pkg::t_geo                 sq_g, r_rg, r_mg;
    logic [bcm_pkg::ROOT_W-1:0]    r_rad, r_s, r_mrad, r_md;
    logic [bcm_pkg::ROOT_W:0]      radsum;
    logic [bcm_pkg::DVD_W-1:0]     r_p [2];
    logic [bcm_pkg::QUO_W-1:0]     quo [2];
    bcm_pkg::t_dpl                 d_in, d_out;
    logic signed [33:0]            cx, cy;
    logic [bcm_pkg::ROOT_W-1:0]    frad, grow;

    assign en        = !(dv_v && i_out_full);
    assign o_mid_pop = en && !i_mid_empty;

    bcm_isqrt #(.PW($bits(bcm_pkg::t_geo))) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (o_mid_pop),
        .i_rad   ({1'b0, i_mid_data.sq}),
        .i_pl    (i_mid_data.geo),
        .o_valid (sq_v),
        .o_root  (root),
        .o_pl    (sq_g)
    );

    assign radsum = {1'b0, root} + {3'b000, sq_g.ra} + {3'b000, sq_g.rb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= 1'b0;
            r_mv <= 1'b0;
        end else if (en) begin
            r_rv <= sq_v;
            r_mv <= r_rv;
        end
        if (en) begin
            r_rg   <= sq_g;
            r_rad  <= radsum[bcm_pkg::ROOT_W:1];
            r_s    <= radsum[bcm_pkg::ROOT_W:1] - {2'b00, sq_g.ra};
            r_md   <= root;
            r_mg   <= r_rg;
            r_mrad <= r_rad;
            r_p[0] <= {33'd0, r_rg.ux} * {32'd0, r_s};
            r_p[1] <= {33'd0, r_rg.uy} * {32'd0, r_s};
        end
    end

    // divisor is the root, registered through r_md and r_dsr so it stays aligned with its item
    logic [bcm_pkg::ROOT_W-1:0] r_dsr;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dsr <= r_md;
        end
    end

    assign d_in.geo = r_mg;
    assign d_in.rad = r_mrad;

    bcm_div #(.PW($bits(bcm_pkg::t_dpl))) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_mv),
        .i_dvd   (r_p),
        .i_dsr   (r_dsr),
        .i_pl    (d_in),
        .o_valid (dv_v),
        .o_quo   (quo),
        .o_pl    (d_out)
    );

    always_comb begin
        if (d_out.geo.encl) begin
            cx   = d_out.geo.pick_a ? 34'(d_out.geo.ax) : 34'(d_out.geo.bx);
            cy   = d_out.geo.pick_a ? 34'(d_out.geo.ay) : 34'(d_out.geo.by);
            frad = d_out.geo.pick_a ? {2'b00, d_out.geo.ra} : {2'b00, d_out.geo.rb};
        end else begin
            cx   = d_out.geo.neg_x ? 34'(d_out.geo.ax) - $signed({1'b0, quo[0]})
                                   : 34'(d_out.geo.ax) + $signed({1'b0, quo[0]});
            cy   = d_out.geo.neg_y ? 34'(d_out.geo.ay) - $signed({1'b0, quo[1]})
                                   : 34'(d_out.geo.ay) + $signed({1'b0, quo[1]});
            frad = d_out.rad;
        end
        grow = (frad >= {2'b00, d_out.geo.ra}) ? frad - {2'b00, d_out.geo.ra} : '0;

        if (cx[33:31] == 3'b000 || cx[33:31] == 3'b111) begin
            o_out_data.merged_x = cx[31:0];
        end else begin
            o_out_data.merged_x = cx[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        if (cy[33:31] == 3'b000 || cy[33:31] == 3'b111) begin
            o_out_data.merged_y = cy[31:0];
        end else begin
            o_out_data.merged_y = cy[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        o_out_data.merged_radius = (|frad[32:31]) ? '1 : frad[30:0];
        o_out_data.growth        = (|grow[32:31]) ? '1 : grow[30:0];
        o_out_data.overlapping   = d_out.geo.ovl;
    end

    assign o_out_push = dv_v && en;
endmodule

@@ sv/bounding_circle_merge_unit.sv @@
// bounding_circle_merge_unit: top level of the two-circle enclosing circle merge
//
//  channel  | handshake         | payload
//  ---------+-------------------+---------------------------
//  request  | push / full       | i_item   (bcm_pkg::t_item)
//  result   | empty / pop       | o_result (bcm_pkg::t_result)
//
// one request per cycle sustained while full stays low; most of the latency comes from the
// 33-stage square root and the 33-stage divider in the back end
// synchronous active-low reset empties both queues and all stage valids
// the front stalls on credit from the 8-entry middle queue, the back end
// freezes only while its last stage holds a result and the result queue is full
module bounding_circle_merge_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    input  bcm_pkg::t_item   i_item,
    output logic             full,
    output logic             empty,
    input  logic             pop,
    output bcm_pkg::t_result o_result
);
    logic                            mid_push, mid_pop, mid_empty, mid_full;
    logic [bcm_pkg::MID_CNT_W-1:0]   mid_count;
    bcm_pkg::t_cls                   mid_in, mid_out;
    logic                            out_push, out_full;
    bcm_pkg::t_result                out_in;
    logic [$clog2(bcm_pkg::OUT_DEPTH+1)-1:0] out_count;

    bcm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .i_mid_count (mid_count),
        .o_mid_push  (mid_push),
        .o_mid_data  (mid_in)
    );

    bcm_fifo #(.W($bits(bcm_pkg::t_cls)), .DEPTH(bcm_pkg::MID_DEPTH)) u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_in),
        .i_pop   (mid_pop),
        .o_data  (mid_out),
        .o_empty (mid_empty),
        .o_full  (mid_full),
        .o_count (mid_count)
    );

    bcm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (mid_empty),
        .i_mid_data  (mid_out),
        .o_mid_pop   (mid_pop),
        .i_out_full  (out_full),
        .o_out_push  (out_push),
        .o_out_data  (out_in)
    );

    bcm_fifo #(.W($bits(bcm_pkg::t_result)), .DEPTH(bcm_pkg::OUT_DEPTH)) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_in),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty),
        .o_full  (out_full),
        .o_count (out_count)
    );

    a_mid_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mid_push |-> !mid_full)
        else $error("middle queue written while full");

    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_push |-> !out_full)
        else $error("result queue written while full");

    a_encl_overlaps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mid_push && mid_in.geo.encl) |-> mid_in.geo.ovl)
        else $error("enclosed pair not flagged as overlapping");

    a_out_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        empty |-> (out_count == '0))
        else $error("result queue count inconsistent");
endmodule
